[rtl/tsrr_pkg.sv]
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared types and constants for the tile source rectangle resolver.
// ----------------------------------------------------------------------------
package tsrr_pkg;

  localparam logic [31:0] FlipXBit = 32'h8000_0000;
  localparam logic [31:0] FlipYBit = 32'h4000_0000;
  localparam logic [31:0] DiagBit  = 32'h2000_0000;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  localparam logic [1:0] CFG_MAP_TW = 2'd0;
  localparam logic [1:0] CFG_MAP_TH = 2'd1;
  localparam logic [1:0] CFG_CAM_X  = 2'd2;
  localparam logic [1:0] CFG_CAM_Y  = 2'd3;

  localparam int unsigned DivSteps = 29;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture the input request
    logic scan_step;  // compare one slot
    logic div_start;  // set up the divider
    logic div_step;   // one quotient bit
    logic mul_step;   // form products
    logic zero_out;   // result is all zero
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic req_resolve;
    logic word_zero;
    logic scan_last;
    logic hit_ok;
    logic div_last;
  } stat_t;

endpackage

[rtl/tsrr_ctrl.sv]
// ----------------------------------------------------------------------------
// tsrr_ctrl
// Sequencer: slot scan, serial divide, multiply, then hold the result.
// ----------------------------------------------------------------------------
module tsrr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tsrr_pkg::stat_t stat_i,
  output tsrr_pkg::ctrl_t ctrl_o
);
  import tsrr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat_i.req_resolve || stat_i.word_zero) begin
          ctrl_o.zero_out = 1'b1;
          state_d = ST_OUT;
        end else begin
          ctrl_o.scan_step = 1'b1;
          if (stat_i.scan_last) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!stat_i.hit_ok) begin
          ctrl_o.zero_out = 1'b1;
          state_d = ST_OUT;
        end else begin
          ctrl_o.div_step = 1'b1;
          if (stat_i.div_last) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        ctrl_o.mul_step = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // divider setup coincides with the last scan step
    ctrl_o.div_start = ctrl_o.scan_step & stat_i.scan_last;
  end

endmodule

[rtl/tsrr_dp.sv]
// ----------------------------------------------------------------------------
// tsrr_dp
// Datapath: tileset table, slot scan, restoring divider, output products.
// ----------------------------------------------------------------------------
module tsrr_dp #(
  parameter int unsigned TilesetSlots = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsrr_pkg::ctrl_t ctrl_i,
  output tsrr_pkg::stat_t stat_o,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            req_type_i,
  input  logic [2:0]      slot_i,
  input  logic [28:0]     first_gid_i,
  input  logic [9:0]      set_columns_i,
  input  logic [7:0]      set_tile_width_i,
  input  logic [7:0]      set_tile_height_i,
  input  logic            set_present_i,
  input  logic [31:0]     tile_word_i,
  input  logic [11:0]     map_row_i,
  input  logic [11:0]     map_col_i,
  output logic            draw_o,
  output logic            flip_x_o,
  output logic            flip_y_o,
  output logic [17:0]     src_left_o,
  output logic [36:0]     src_top_o,
  output logic [17:0]     src_right_o,
  output logic [36:0]     src_bottom_o,
  output logic signed [20:0] draw_x_o,
  output logic signed [20:0] draw_y_o
);
  import tsrr_pkg::*;

  localparam int unsigned IdxW = (TilesetSlots > 1) ? $clog2(TilesetSlots) : 1;
  localparam int unsigned CntW = $clog2(DivSteps + 1);

  // configuration
  logic [7:0]  map_tw_q, map_th_q;
  logic [15:0] cam_x_q, cam_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_tw_q <= 8'd16;
      map_th_q <= 8'd16;
      cam_x_q  <= '0;
      cam_y_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_TW: map_tw_q <= cfg_data_i[7:0];
        CFG_MAP_TH: map_th_q <= cfg_data_i[7:0];
        CFG_CAM_X:  cam_x_q  <= cfg_data_i;
        CFG_CAM_Y:  cam_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured request
  logic        req_q;
  logic [2:0]  slot_q;
  logic [31:0] word_q;
  logic [11:0] row_q, col_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      req_q  <= req_type_i;
      slot_q <= slot_i;
      word_q <= tile_word_i;
      row_q  <= map_row_i;
      col_q  <= map_col_i;
    end
  end

  // tileset table
  logic [TilesetSlots-1:0] valid_q;
  logic [28:0] gid_mem   [TilesetSlots];
  logic [9:0]  cols_mem  [TilesetSlots];
  logic [7:0]  tw_mem    [TilesetSlots];
  logic [7:0]  th_mem    [TilesetSlots];
  logic        pres_mem  [TilesetSlots];

  logic load_we;
  assign load_we = ctrl_i.load_in && (req_type_i == REQ_LOAD) &&
                   ({29'd0, slot_i} < 32'(TilesetSlots));

  logic [IdxW-1:0] widx;
  assign widx = IdxW'(slot_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_we) begin
      valid_q[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      gid_mem[widx]  <= first_gid_i;
      cols_mem[widx] <= set_columns_i;
      tw_mem[widx]   <= set_tile_width_i;
      th_mem[widx]   <= set_tile_height_i;
      pres_mem[widx] <= set_present_i;
    end
  end

  // slot scan: one slot per cycle, ascending; >= keeps the highest slot on ties
  logic [IdxW:0]   scan_q;
  logic            found_q;
  logic [IdxW-1:0] best_q;
  logic [28:0]     best_gid_q;
  logic [28:0]     id;
  logic [IdxW-1:0] sidx;
  logic            take;

  assign id   = word_q[28:0];
  assign sidx = scan_q[IdxW-1:0];
  assign take = valid_q[sidx] && (gid_mem[sidx] <= id) &&
                (!found_q || gid_mem[sidx] >= best_gid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.load_in) begin
      scan_q  <= '0;
      found_q <= 1'b0;
    end else if (ctrl_i.scan_step) begin
      scan_q <= scan_q + 1'b1;
      if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_step && take) begin
      best_q     <= sidx;
      best_gid_q <= gid_mem[sidx];
    end
  end

  // entry chosen on the final scan step, with this cycle's candidate folded in
  logic [IdxW-1:0] pick;
  logic [28:0]     pick_gid;
  assign pick     = take ? sidx : best_q;
  assign pick_gid = take ? gid_mem[sidx] : best_gid_q;

  // restoring divider, one quotient bit per cycle
  logic [28:0]    quo_q;
  logic [9:0]     rem_q;
  logic [9:0]     div_q;
  logic [7:0]     tw_q, th_q;
  logic           hit_q;
  logic [CntW-1:0] dcnt_q;
  logic [10:0]    trial;

  assign trial = {rem_q, quo_q[28]} - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      dcnt_q <= '0;
    end else if (ctrl_i.div_start) begin
      hit_q  <= (take || found_q) && pres_mem[pick];
      dcnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      quo_q <= id - pick_gid;
      rem_q <= '0;
      div_q <= (cols_mem[pick] == '0) ? 10'd1 : cols_mem[pick];
      tw_q  <= (tw_mem[pick] == '0) ? 8'd1 : tw_mem[pick];
      th_q  <= (th_mem[pick] == '0) ? 8'd1 : th_mem[pick];
    end else if (ctrl_i.div_step) begin
      if (!trial[10]) begin
        rem_q <= trial[9:0];
        quo_q <= {quo_q[27:0], 1'b1};
      end else begin
        rem_q <= {rem_q[8:0], quo_q[28]};
        quo_q <= {quo_q[27:0], 1'b0};
      end
    end
  end

  // output registers
  logic [17:0] left;
  logic [36:0] top;
  logic [20:0] px, py;
  assign left = {8'd0, rem_q} * {10'd0, tw_q};
  assign top  = {8'd0, quo_q} * {29'd0, th_q};
  assign px   = 21'({9'd0, col_q} * {13'd0, map_tw_q}) + {14'd0, map_tw_q[7:1]}
                - {5'd0, cam_x_q};
  assign py   = 21'({9'd0, row_q} * {13'd0, map_th_q}) + {14'd0, map_th_q[7:1]}
                - {5'd0, cam_y_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.zero_out) begin
      draw_o <= 1'b0; flip_x_o <= 1'b0; flip_y_o <= 1'b0;
      src_left_o <= '0; src_top_o <= '0; src_right_o <= '0; src_bottom_o <= '0;
      draw_x_o <= '0; draw_y_o <= '0;
    end else if (ctrl_i.mul_step) begin
      draw_o       <= 1'b1;
      flip_x_o     <= |(word_q & FlipXBit);
      flip_y_o     <= |(word_q & FlipYBit);
      src_left_o   <= left;
      src_top_o    <= top;
      src_right_o  <= left + {10'd0, tw_q} - 18'd1;
      src_bottom_o <= top + {29'd0, th_q} - 37'd1;
      draw_x_o     <= px;
      draw_y_o     <= py;
    end
  end

  logic unused_diag;
  assign unused_diag = |(word_q & DiagBit);

  assign stat_o.req_resolve = (req_q == REQ_RESOLVE);
  assign stat_o.word_zero   = (word_q == '0) | (unused_diag & 1'b0);
  assign stat_o.scan_last   = (scan_q == (IdxW+1)'(TilesetSlots - 1));
  assign stat_o.hit_ok      = hit_q;
  assign stat_o.div_last    = (dcnt_q == CntW'(DivSteps - 1));

endmodule

[rtl/tile_source_rect_resolver_unit.sv]
// ----------------------------------------------------------------------------
// tile_source_rect_resolver_unit
// Tileset lookup and source rectangle / draw position for one map cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries load or resolve requests.
//   A load writes one tileset slot; a resolve maps a raw cell word to a
//   source rectangle and screen centre. Every request yields one result on
//   the output channel (out_valid_o/out_ready_i); loads give all zeros.
//   Config writes (cfg_valid_i/cfg_ready_o, index, data) set cell size and
//   camera; write them only while idle.
// Sequence:
//   A resolve captures the request, scans the slots, runs the serial divide
//   and forms the products before the result shows; loads and zero words
//   skip the scan and the divide. One request is in flight at a time, so
//   a new request is not taken until the current result has been accepted.
// Reset clears all slot valid bits and loads the register defaults.
// A stalled receiver holds the result; no new request is taken until then.
// ----------------------------------------------------------------------------
module tile_source_rect_resolver_unit #(
  parameter int unsigned TILESET_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [2:0]  slot_i,
  input  logic [28:0] first_gid_i,
  input  logic [9:0]  set_columns_i,
  input  logic [7:0]  set_tile_width_i,
  input  logic [7:0]  set_tile_height_i,
  input  logic        set_present_i,
  input  logic [31:0] tile_word_i,
  input  logic [11:0] map_row_i,
  input  logic [11:0] map_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        draw_o,
  output logic        flip_x_o,
  output logic        flip_y_o,
  output logic [17:0] src_left_o,
  output logic [36:0] src_top_o,
  output logic [17:0] src_right_o,
  output logic [36:0] src_bottom_o,
  output logic signed [20:0] draw_x_o,
  output logic signed [20:0] draw_y_o
);
  import tsrr_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tsrr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  tsrr_dp #(.TilesetSlots(TILESET_SLOTS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .req_type_i, .slot_i, .first_gid_i, .set_columns_i, .set_tile_width_i,
    .set_tile_height_i, .set_present_i, .tile_word_i, .map_row_i, .map_col_i,
    .draw_o, .flip_x_o, .flip_y_o, .src_left_o, .src_top_o, .src_right_o,
    .src_bottom_o, .draw_x_o, .draw_y_o
  );

endmodule

[rtl/tsrr_checker.sv]
// ----------------------------------------------------------------------------
// tsrr_checker
// Port-level checks on the resolver's request/result sequencing.
// ----------------------------------------------------------------------------
module tsrr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic draw_o,
  input logic flip_x_o,
  input logic flip_y_o
);

  // one request in flight: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken with result pending");

  // an accepted request never shows its result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  // flips only on drawn tiles
  a_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !draw_o) |-> (!flip_x_o && !flip_y_o))
    else $error("flip on undrawn tile");

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(draw_o)))
    else $error("result dropped under stall");

endmodule

bind tile_source_rect_resolver_unit tsrr_checker u_tsrr_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .draw_o, .flip_x_o, .flip_y_o
);

[dv/tb_tile_source_rect_resolver_unit.sv]
// ----------------------------------------------------------------------------
// tb_tile_source_rect_resolver_unit
// Self-checking bench: tileset loads and map tile resolves are driven with
// random handshake gaps; a local predictor tracks the slot table and the
// cell/camera registers and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_tile_source_rect_resolver_unit;
  import tsrr_pkg::*;

  localparam int unsigned Slots = 8;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic        draw;
    logic        flip_x;
    logic        flip_y;
    logic [17:0] src_left;
    logic [36:0] src_top;
    logic [17:0] src_right;
    logic [36:0] src_bottom;
    logic [20:0] draw_x;
    logic [20:0] draw_y;
  } rect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic [2:0] slot_i = '0;
  logic [28:0] first_gid_i = '0;
  logic [9:0] set_columns_i = '0;
  logic [7:0] set_tile_width_i = '0;
  logic [7:0] set_tile_height_i = '0;
  logic set_present_i = 1'b0;
  logic [31:0] tile_word_i = '0;
  logic [11:0] map_row_i = '0;
  logic [11:0] map_col_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic draw_o, flip_x_o, flip_y_o;
  logic [17:0] src_left_o, src_right_o;
  logic [36:0] src_top_o, src_bottom_o;
  logic signed [20:0] draw_x_o, draw_y_o;

  tile_source_rect_resolver_unit #(.TILESET_SLOTS(Slots)) dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  cell_w, cell_h;
  logic [15:0] cam_x, cam_y;
  logic        tbl_valid [Slots];
  logic [28:0] tbl_gid [Slots];
  logic [9:0]  tbl_cols [Slots];
  logic [7:0]  tbl_tw [Slots];
  logic [7:0]  tbl_th [Slots];
  logic        tbl_present [Slots];

  rect_t expected_rects[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    loads_sent = 0;
  int    resolves_sent = 0;
  int    idle_cycles = 0;
  bit    gaps_on = 1'b1;
  bit    sink_hold = 1'b0;

  function automatic rect_t resolve_rect(logic [31:0] word, logic [11:0] row,
                                         logic [11:0] col);
    rect_t r;
    logic [28:0] id;
    int best;
    logic [63:0] cols, tw, th, lid, left, top;
    logic [63:0] px, py;
    r = '0;
    best = -1;
    if (word == 32'd0) return r;
    id = word[28:0];
    for (int i = 0; i < Slots; i++)
      if (tbl_valid[i] && tbl_gid[i] <= id)
        if (best < 0 || tbl_gid[i] >= tbl_gid[best]) best = i;
    if (best < 0 || !tbl_present[best]) return r;
    cols = (tbl_cols[best] == 0) ? 64'd1 : 64'(tbl_cols[best]);
    tw = (tbl_tw[best] == 0) ? 64'd1 : 64'(tbl_tw[best]);
    th = (tbl_th[best] == 0) ? 64'd1 : 64'(tbl_th[best]);
    lid = 64'(id - tbl_gid[best]);
    left = (lid % cols) * tw;
    top = (lid / cols) * th;
    px = 64'(col) * 64'(cell_w) + 64'(cell_w >> 1) - 64'(cam_x);
    py = 64'(row) * 64'(cell_h) + 64'(cell_h >> 1) - 64'(cam_y);
    r.draw = 1'b1;
    r.flip_x = word[31];
    r.flip_y = word[30];
    r.src_left = left[17:0];
    r.src_top = top[36:0];
    r.src_right = 18'(left + tw - 1);
    r.src_bottom = 37'(top + th - 1);
    r.draw_x = px[20:0];
    r.draw_y = py[20:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want,
             results_seen);
  endtask

  task automatic random_gap();
    if (gaps_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
  endtask

  task automatic send_request(logic rt, logic [2:0] sl, logic [28:0] gid,
                              logic [9:0] cols, logic [7:0] tw, logic [7:0] th,
                              logic pres, logic [31:0] word, logic [11:0] row,
                              logic [11:0] col);
    random_gap();
    req_type_i <= rt; slot_i <= sl; first_gid_i <= gid; set_columns_i <= cols;
    set_tile_width_i <= tw; set_tile_height_i <= th; set_present_i <= pres;
    tile_word_i <= word; map_row_i <= row; map_col_i <= col;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (rt == REQ_LOAD) begin
      expected_rects = {expected_rects, rect_t'('0)};
      tbl_valid[sl] = 1'b1; tbl_gid[sl] = gid; tbl_cols[sl] = cols;
      tbl_tw[sl] = tw; tbl_th[sl] = th; tbl_present[sl] = pres;
      loads_sent++;
    end else begin
      expected_rects = {expected_rects, resolve_rect(word, row, col)};
      resolves_sent++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // block is busy for this cycle anyway
    @(negedge clk_i);
  endtask

  task automatic load_slot(logic [2:0] sl, logic [28:0] gid, logic [9:0] cols,
                           logic [7:0] tw, logic [7:0] th, logic pres);
    send_request(REQ_LOAD, sl, gid, cols, tw, th, pres, $urandom,
                 12'($urandom), 12'($urandom));
  endtask

  task automatic resolve_tile(logic [31:0] word, logic [11:0] row, logic [11:0] col);
    send_request(REQ_RESOLVE, 3'($urandom), 29'($urandom), 10'($urandom),
                 8'($urandom), 8'($urandom), 1'($urandom), word, row, col);
  endtask

  task automatic drain();
    while (expected_rects.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index_i <= idx; cfg_data_i <= val; cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAP_TW: cell_w = val[7:0];
      CFG_MAP_TH: cell_h = val[7:0];
      CFG_CAM_X:  cam_x = val;
      default:    cam_y = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_view(logic [7:0] w, logic [7:0] h, logic [15:0] x, logic [15:0] y);
    drain();
    write_reg(CFG_MAP_TW, {8'd0, w});
    write_reg(CFG_MAP_TH, {8'd0, h});
    write_reg(CFG_CAM_X, x);
    write_reg(CFG_CAM_Y, y);
  endtask

  // id near a loaded slot so lookups mostly hit
  function automatic logic [31:0] pick_word();
    logic [28:0] base;
    logic [2:0] sl;
    sl = 3'($urandom);
    base = tbl_valid[sl] ? tbl_gid[sl] : 29'($urandom);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      2: return {3'($urandom), 29'd0};
      default: return {3'($urandom), 29'(base + $urandom_range(0, 3000))};
    endcase
  endfunction

  task automatic test_loads_and_specials();
    // resolve with empty table, and empty word
    resolve_tile(32'h0000_0005, 12'd0, 12'd0);
    resolve_tile(32'd0, 12'd1, 12'd1);
    load_slot(3'd0, 29'd1, 10'd8, 8'd16, 8'd16, 1'b1);
    load_slot(3'd7, 29'h1FFF_FFFF, 10'd1023, 8'd255, 8'd255, 1'b1);
    load_slot(3'd3, 29'd100, 10'd0, 8'd0, 8'd0, 1'b1);
    load_slot(3'd5, 29'd200, 10'd4, 8'd8, 8'd8, 1'b0);
    resolve_tile(32'h0000_0001, 12'd0, 12'd0);
    resolve_tile(32'hE000_0009, 12'hFFF, 12'hFFF);
    resolve_tile(32'h8000_0064, 12'd3, 12'd4);
    resolve_tile(32'h4000_0070, 12'd3, 12'd4);
    resolve_tile(32'h2000_00C8, 12'd3, 12'd4);
    resolve_tile(32'hFFFF_FFFF, 12'hFFF, 12'd0);
    resolve_tile(32'h1FFF_FFFE, 12'd0, 12'hFFF);
    resolve_tile(32'hE000_0000, 12'd0, 12'd0);
    // equal first ids: highest slot wins
    load_slot(3'd1, 29'd50, 10'd3, 8'd10, 8'd10, 1'b1);
    load_slot(3'd2, 29'd50, 10'd5, 8'd7, 8'd9, 1'b1);
    resolve_tile(32'h0000_0040, 12'd2, 12'd2);
    load_slot(3'd6, 29'd0, 10'd1023, 8'd1, 8'd1, 1'b1);
    resolve_tile(32'h1FFF_FFF0, 12'd5, 12'd6);
  endtask

  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 7) == 0)
        load_slot(3'($urandom), ($urandom_range(0, 3) == 0) ? 29'($urandom)
                  : 29'($urandom_range(0, 20000)), 10'($urandom), 8'($urandom),
                  8'($urandom), ($urandom_range(0, 4) != 0));
      else
        resolve_tile(pick_word(), 12'($urandom), 12'($urandom));
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      test_random_mix(6);
    join
  endtask

  // result checker
  always @(posedge clk_i) begin
    rect_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_rects.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_rects.pop_front();
        if (draw_o !== want.draw) report_mismatch("draw", draw_o, want.draw);
        if (flip_x_o !== want.flip_x) report_mismatch("flip_x", flip_x_o, want.flip_x);
        if (flip_y_o !== want.flip_y) report_mismatch("flip_y", flip_y_o, want.flip_y);
        if (src_left_o !== want.src_left)
          report_mismatch("src_left", src_left_o, want.src_left);
        if (src_top_o !== want.src_top) report_mismatch("src_top", src_top_o, want.src_top);
        if (src_right_o !== want.src_right)
          report_mismatch("src_right", src_right_o, want.src_right);
        if (src_bottom_o !== want.src_bottom)
          report_mismatch("src_bottom", src_bottom_o, want.src_bottom);
        if (draw_x_o !== want.draw_x) report_mismatch("draw_x", draw_x_o, want.draw_x);
        if (draw_y_o !== want.draw_y) report_mismatch("draw_y", draw_y_o, want.draw_y);
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        out_ready_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress (requests, results, config writes)
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no progress");
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cell_w = 8'd16; cell_h = 8'd16; cam_x = '0; cam_y = '0;
    for (int i = 0; i < Slots; i++) begin
      tbl_valid[i] = 1'b0; tbl_gid[i] = '0; tbl_cols[i] = '0;
      tbl_tw[i] = '0; tbl_th[i] = '0; tbl_present[i] = 1'b0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_loads_and_specials();
    set_view(8'd255, 8'd255, 16'd0, 16'd0);
    test_random_mix(250);
    test_backpressure();
    set_view(8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    test_random_mix(250);
    set_view(8'd0, 8'd0, 16'h1234, 16'h8000);
    test_random_mix(200);
    set_view(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
             16'($urandom), 16'($urandom));
    test_random_mix(300);
    drain();
    gaps_on = 1'b0;
    set_view(8'd16, 8'd16, 16'd37, 16'd5);
    test_random_mix(270);
    drain();
    repeat (50) @(negedge clk_i);
    $display("covered %0d loads and %0d resolves, %0d results checked",
             loads_sent, resolves_sent, results_seen);
    $display("view settings: cell size 0/1/255, camera 0 to 65535");
    if (mismatches == 0 && expected_rects.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tsrr_pkg.sv
rtl/tsrr_ctrl.sv
rtl/tsrr_dp.sv
rtl/tile_source_rect_resolver_unit.sv
rtl/tsrr_checker.sv
dv/tb_tile_source_rect_resolver_unit.sv
